>>> design/xmr_pkg.sv
// ----------------------------------------------------------------------------
// xmr_pkg
// Shared types, protocol characters and codes of the xmodem-1k receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package xmr_pkg;
   localparam int ADDR_BITS = 20;
   localparam logic [20:0] ADDR_SPAN = 21'd1 << ADDR_BITS;

   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_EOT = 8'h04;

   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_NORMAL = 3'd0;
   localparam logic [2:0] ST_ETX    = 3'd1;
   localparam logic [2:0] ST_CANCEL = 3'd2;
   localparam logic [2:0] ST_SYNC   = 3'd3;
   localparam logic [2:0] ST_RETRY  = 3'd4;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_RETRIES  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd2;

   // one result record: up to three per item, with count
   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        wr_valid;
      logic [19:0] wr_offset;
      logic [7:0]  wr_data;
      logic [20:0] committed_length;
      logic        done_res;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
   } batch_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
   } item_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
         x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
      return x;
   endfunction
endpackage
`default_nettype wire

>>> design/xmr_engine.sv
// ----------------------------------------------------------------------------
// xmr_engine
// Protocol state machine: takes one item per cycle, emits a batch of results.
// ----------------------------------------------------------------------------
`default_nettype none
module xmr_engine (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   input  xmr_pkg::item_type in_item,
   input  wire  [20:0]       cap_cfg,
   input  wire  [7:0]        retries_cfg,
   input  wire  [15:0]       timeout_cfg,
   output xmr_pkg::batch_type out_batch,
   output logic              out_valid
);
   import xmr_pkg::*;

   localparam logic [2:0] PH_WAIT = 3'd0, PH_CANWAIT = 3'd1, PH_PACKET = 3'd2,
                          PH_FLUSH = 3'd3, PH_DONE = 3'd4;
   localparam logic [1:0] MODE_C = 2'd0, MODE_NAK = 2'd1, MODE_NONE = 2'd2;
   localparam logic [2:0] PR_NONE = 3'd0, PR_ACK_END = 3'd1, PR_ACK_ETX = 3'd2,
                          PR_ACK_CAN = 3'd3, PR_NAK = 3'd4, PR_CAN_SYNC = 3'd5,
                          PR_CAN_RETRY = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  mode_ff, mode_in;
   logic        crc_mode_ff, crc_mode_in;
   logic [7:0]  exp_ff, exp_in;
   logic [7:0]  wretry_ff, wretry_in;
   logic [7:0]  retrans_ff, retrans_in;
   logic [15:0] quiet_ff, quiet_in;
   logic [10:0] idx_ff, idx_in;
   logic        long_ff, long_in;
   logic [7:0]  blk_ff, blk_in;
   logic        hdr_ff, hdr_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] rchk_ff, rchk_in;
   logic [20:0] off_ff, off_in;
   logic [2:0]  pend_ff, pend_in;
   logic [2:0]  stat_ff, stat_in;
   batch_type   batch_ff, batch_in;
   logic        ov_ff;

   logic [20:0] cap_lim;
   assign cap_lim = (cap_cfg > ADDR_SPAN) ? ADDR_SPAN : cap_cfg;

   always_comb begin
      logic [7:0]  lim;
      logic [7:0]  b;
      logic [10:0] len;
      logic [10:0] total;
      logic [10:0] idx;
      logic [20:0] woff;
      logic [20:0] avail;
      logic        in_seq, prv, chk;
      logic [1:0]  n;
      logic [7:0]  tx [3];
      logic        wrv;
      logic [19:0] wro;
      logic [15:0] q;
      phase_in = phase_ff; mode_in = mode_ff; crc_mode_in = crc_mode_ff;
      exp_in = exp_ff; wretry_in = wretry_ff; retrans_in = retrans_ff;
      quiet_in = quiet_ff; idx_in = idx_ff; long_in = long_ff; blk_in = blk_ff;
      hdr_in = hdr_ff; crc_in = crc_ff; sum_in = sum_ff; rchk_in = rchk_ff;
      off_in = off_ff; pend_in = pend_ff; stat_in = stat_ff;
      lim = (retries_cfg == 8'd0) ? 8'd1 : retries_cfg;
      b = in_item.rx_byte;
      n = 2'd0; tx[0] = 8'd0; tx[1] = 8'd0; tx[2] = 8'd0;
      wrv = 1'b0; wro = '0;
      len = long_ff ? 11'd1024 : 11'd128;
      total = 11'd2 + len + (crc_mode_ff ? 11'd2 : 11'd1);
      idx = idx_ff;
      woff = off_ff + 21'(idx - 11'd2);
      avail = '0; in_seq = 1'b0; prv = 1'b0; chk = 1'b0; q = '0;
      batch_in = '0;
      if (in_valid) begin
         if (in_item.operation == OP_START) begin
            phase_in = PH_WAIT; wretry_in = '0; quiet_in = '0; mode_in = MODE_C;
            crc_mode_in = 1'b0; exp_in = 8'd1; retrans_in = retries_cfg;
            idx_in = '0; long_in = 1'b0; blk_in = '0; hdr_in = 1'b0; crc_in = '0;
            sum_in = '0; rchk_in = '0; off_in = '0; pend_in = PR_NONE; stat_in = '0;
         end else if ((in_item.operation == OP_BYTE || in_item.operation == OP_TICK) &&
                      phase_ff != PH_DONE) begin
            // wait-fail and flush-finish are flagged then applied below
            logic wfail, ffin;
            wfail = 1'b0; ffin = 1'b0;
            if (in_item.operation == OP_BYTE) begin
               quiet_in = '0;
               unique case (phase_ff)
                  PH_WAIT: begin
                     if (b == CH_SOH || b == CH_STX) begin
                        if (mode_ff == MODE_C) crc_mode_in = 1'b1;
                        mode_in = MODE_NONE;
                        long_in = (b == CH_STX);
                        idx_in = '0; blk_in = '0; hdr_in = 1'b0; crc_in = '0;
                        sum_in = '0; rchk_in = '0; phase_in = PH_PACKET;
                     end else if (b == CH_ETX) begin
                        phase_in = PH_FLUSH; pend_in = PR_ACK_ETX;
                     end else if (b == CH_EOT) begin
                        phase_in = PH_FLUSH; pend_in = PR_ACK_END;
                     end else if (b == CH_CAN) begin
                        phase_in = PH_CANWAIT;
                     end else begin
                        wfail = 1'b1;
                     end
                  end
                  PH_CANWAIT: begin
                     if (b == CH_CAN) begin
                        phase_in = PH_FLUSH; pend_in = PR_ACK_CAN;
                     end else begin
                        wfail = 1'b1;
                     end
                  end
                  PH_PACKET: begin
                     if (idx == 11'd0) blk_in = b;
                     else if (idx == 11'd1) hdr_in = (b == ~blk_ff);
                     else if (idx < 11'd2 + len) begin
                        sum_in = sum_ff + b;
                        crc_in = crc_byte(crc_ff, b);
                        if (hdr_ff && blk_ff == exp_ff && woff < cap_lim) begin
                           wrv = 1'b1; wro = woff[19:0]; n = 2'd1;
                        end
                     end else begin
                        rchk_in = {rchk_ff[7:0], b};
                     end
                     idx_in = idx + 11'd1;
                     if (idx_in >= total) begin
                        in_seq = (blk_in == exp_ff);
                        prv = (blk_in == exp_ff - 8'd1);
                        chk = crc_mode_ff ? (crc_in == rchk_in) : (sum_in == rchk_in[7:0]);
                        if (hdr_in && (in_seq || prv) && chk) begin
                           if (in_seq) begin
                              avail = (cap_lim > off_ff) ? cap_lim - off_ff : '0;
                              off_in = off_ff + ((avail < 21'(len)) ? avail : 21'(len));
                              exp_in = exp_ff + 8'd1;
                              retrans_in = retries_cfg;
                              tx[n] = CH_ACK; n = n + 2'd1;
                              phase_in = PH_WAIT; wretry_in = '0; quiet_in = '0;
                           end else if (retrans_ff <= 8'd1) begin
                              retrans_in = '0;
                              phase_in = PH_FLUSH; pend_in = PR_CAN_RETRY; quiet_in = '0;
                           end else begin
                              retrans_in = retrans_ff - 8'd1;
                              tx[n] = CH_ACK; n = n + 2'd1;
                              phase_in = PH_WAIT; wretry_in = '0; quiet_in = '0;
                           end
                        end else begin
                           phase_in = PH_FLUSH; pend_in = PR_NAK; quiet_in = '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end else begin
               q = quiet_ff + 16'd1;
               quiet_in = q;
               if (q >= timeout_cfg || q == 16'd0) begin
                  quiet_in = '0;
                  if (phase_ff == PH_WAIT || phase_ff == PH_CANWAIT) wfail = 1'b1;
                  else if (phase_ff == PH_PACKET) begin
                     phase_in = PH_FLUSH; pend_in = PR_NAK;
                  end else if (phase_ff == PH_FLUSH) ffin = 1'b1;
               end
            end
            if (wfail) begin
               if (mode_ff == MODE_C) begin
                  tx[n] = CH_C; n = n + 2'd1;
               end else if (mode_ff == MODE_NAK) begin
                  tx[n] = CH_NAK; n = n + 2'd1;
               end
               phase_in = PH_WAIT;
               wretry_in = wretry_ff + 8'd1;
               if (wretry_in >= lim) begin
                  if (mode_ff == MODE_C) begin
                     mode_in = MODE_NAK; wretry_in = '0;
                  end else begin
                     phase_in = PH_FLUSH; pend_in = PR_CAN_SYNC; quiet_in = '0;
                  end
               end
            end
            if (ffin) begin
               pend_in = PR_NONE;
               unique case (pend_ff)
                  PR_NAK: begin
                     tx[0] = CH_NAK; n = 2'd1;
                     phase_in = PH_WAIT; wretry_in = '0; quiet_in = '0;
                  end
                  PR_CAN_SYNC, PR_CAN_RETRY: begin
                     tx[0] = CH_CAN; tx[1] = CH_CAN; tx[2] = CH_CAN; n = 2'd3;
                     stat_in = (pend_ff == PR_CAN_SYNC) ? ST_SYNC : ST_RETRY;
                     phase_in = PH_DONE;
                  end
                  PR_ACK_END, PR_ACK_ETX, PR_ACK_CAN: begin
                     tx[0] = CH_ACK; n = 2'd1;
                     stat_in = (pend_ff == PR_ACK_END) ? ST_NORMAL :
                               (pend_ff == PR_ACK_ETX) ? ST_ETX : ST_CANCEL;
                     phase_in = PH_DONE;
                  end
                  default: begin
                     phase_in = PH_WAIT; wretry_in = '0; quiet_in = '0;
                  end
               endcase
            end
            batch_in.count = n;
            batch_in.r0.tx_valid = !wrv; batch_in.r0.tx_byte = wrv ? 8'd0 : tx[0];
            batch_in.r0.wr_valid = wrv; batch_in.r0.wr_offset = wro;
            batch_in.r0.wr_data = wrv ? b : 8'd0;
            batch_in.r1.tx_valid = 1'b1; batch_in.r1.tx_byte = wrv ? tx[1] : tx[1];
            batch_in.r2.tx_valid = 1'b1; batch_in.r2.tx_byte = tx[2];
            if (wrv) begin
               batch_in.r1.tx_byte = tx[1];
            end
            batch_in.r0.committed_length = off_in;
            batch_in.r1.committed_length = off_in;
            batch_in.r2.committed_length = off_in;
            batch_in.r0.done_res = (phase_in == PH_DONE);
            batch_in.r1.done_res = (phase_in == PH_DONE);
            batch_in.r2.done_res = (phase_in == PH_DONE);
            batch_in.r0.status = (phase_in == PH_DONE) ? stat_in : ST_NORMAL;
            batch_in.r1.status = (phase_in == PH_DONE) ? stat_in : ST_NORMAL;
            batch_in.r2.status = (phase_in == PH_DONE) ? stat_in : ST_NORMAL;
            batch_in.r0.last = (n == 2'd1);
            batch_in.r1.last = (n == 2'd2);
            batch_in.r2.last = (n == 2'd3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT; mode_ff <= MODE_C; crc_mode_ff <= 1'b0; exp_ff <= 8'd1;
         wretry_ff <= '0; retrans_ff <= 8'd25; quiet_ff <= '0; idx_ff <= '0;
         long_ff <= 1'b0; blk_ff <= '0; hdr_ff <= 1'b0; crc_ff <= '0; sum_ff <= '0;
         rchk_ff <= '0; off_ff <= '0; pend_ff <= PR_NONE; stat_ff <= '0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; mode_ff <= mode_in; crc_mode_ff <= crc_mode_in;
         exp_ff <= exp_in; wretry_ff <= wretry_in; retrans_ff <= retrans_in;
         quiet_ff <= quiet_in; idx_ff <= idx_in; long_ff <= long_in; blk_ff <= blk_in;
         hdr_ff <= hdr_in; crc_ff <= crc_in; sum_ff <= sum_in; rchk_ff <= rchk_in;
         off_ff <= off_in; pend_ff <= pend_in; stat_ff <= stat_in;
         ov_ff <= in_valid && (batch_in.count != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
   end

   assign out_batch = batch_ff;
   assign out_valid = ov_ff;
endmodule
`default_nettype wire

>>> design/xmr_rsp_queue.sv
// ----------------------------------------------------------------------------
// xmr_rsp_queue
// Batch queue between engine and result port; unrolls batches one beat a pop.
// ----------------------------------------------------------------------------
`default_nettype none
module xmr_rsp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  xmr_pkg::batch_type  in_batch,
   output logic                almost_full,
   output logic                empty,
   input  wire                 pop,
   output xmr_pkg::rsp_type    head
);
   import xmr_pkg::*;

   localparam int DEPTH = 4;

   batch_type  mem [DEPTH];
   logic [1:0] wptr_ff, rptr_ff;
   logic [2:0] cnt_ff;
   logic [1:0] sub_ff;
   logic       deq;
   batch_type  cur;

   assign cur   = mem[rptr_ff];
   assign empty = (cnt_ff == 3'd0);
   // engine has one batch in flight, so keep two slots spare
   assign almost_full = (cnt_ff >= 3'd2);

   always_comb begin
      unique case (sub_ff)
         2'd0:    head = cur.r0;
         2'd1:    head = cur.r1;
         default: head = cur.r2;
      endcase
   end

   assign deq = pop && !empty && (sub_ff + 2'd1 == cur.count);

   always_ff @(posedge clock) begin
      if (in_valid) mem[wptr_ff] <= in_batch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0; rptr_ff <= '0; cnt_ff <= '0; sub_ff <= '0;
      end else begin
         if (in_valid) wptr_ff <= wptr_ff + 2'd1;
         if (deq) begin
            rptr_ff <= rptr_ff + 2'd1;
            sub_ff <= '0;
         end else if (pop && !empty) begin
            sub_ff <= sub_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + {2'd0, in_valid} - {2'd0, deq};
      end
   end
endmodule
`default_nettype wire

>>> design/xmodem_1k_receiver.sv
// an accepted item's batch is registered in the engine, then written into
//   the result queue, whose head drives the ports until it is popped
// throughput: one item per cycle while the result queue holds fewer than
//   two batches; each item gives up to three results, popped one per cycle
// reset: synchronous; clears session state, registers return to defaults
// ----------------------------------------------------------------------------
// xmodem_1k_receiver
// XMODEM / XMODEM-1K receiver with CRC-16 or checksum and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module xmodem_1k_receiver (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [1:0]  req_operation,
   input  wire  [7:0]  req_rx_byte,
   output logic        empty,
   input  wire         pop,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_wr_valid,
   output logic [19:0] rsp_wr_offset,
   output logic [7:0]  rsp_wr_data,
   output logic [20:0] rsp_committed_length,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [20:0] csr_data
);
   import xmr_pkg::*;

   logic [20:0] cap_ff;
   logic [7:0]  ret_ff;
   logic [15:0] tmo_ff;
   item_type    item;
   batch_type   batch;
   logic        bvalid, afull;
   rsp_type     head;

   assign csr_ready = 1'b1;
   assign full = afull;
   assign item.operation = req_operation;
   assign item.rx_byte = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 21'h100000; ret_ff <= 8'd25; tmo_ff <= 16'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_ff <= csr_data;
            CSR_RETRIES:  ret_ff <= csr_data[7:0];
            CSR_TIMEOUT:  tmo_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   xmr_engine u_engine (
      .clock(clock), .reset(reset), .in_valid(push && !afull), .in_item(item),
      .cap_cfg(cap_ff), .retries_cfg(ret_ff), .timeout_cfg(tmo_ff),
      .out_batch(batch), .out_valid(bvalid)
   );

   xmr_rsp_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(bvalid), .in_batch(batch),
      .almost_full(afull), .empty(empty), .pop(pop), .head(head)
   );

   assign rsp_tx_valid = head.tx_valid;
   assign rsp_tx_byte = head.tx_byte;
   assign rsp_wr_valid = head.wr_valid;
   assign rsp_wr_offset = head.wr_offset;
   assign rsp_wr_data = head.wr_data;
   assign rsp_committed_length = head.committed_length;
   assign rsp_done_res = head.done_res;
   assign rsp_status = head.status;
   assign rsp_last = head.last;
endmodule
`default_nettype wire

>>> bench/xmr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmr_checker
// Watches the item, result and register channels of the xmodem-1k receiver,
// keeps its own model of the session and compares every result beat.
// ----------------------------------------------------------------------------
module xmr_checker
   import xmr_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   input  wire         full,
   input  wire  [1:0]  req_operation,
   input  wire  [7:0]  req_rx_byte,
   input  wire         empty,
   input  wire         pop,
   input  wire         rsp_tx_valid,
   input  wire  [7:0]  rsp_tx_byte,
   input  wire         rsp_wr_valid,
   input  wire  [19:0] rsp_wr_offset,
   input  wire  [7:0]  rsp_wr_data,
   input  wire  [20:0] rsp_committed_length,
   input  wire         rsp_done_res,
   input  wire  [2:0]  rsp_status,
   input  wire         rsp_last,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [20:0] csr_data,
   output int          errors,
   output int          outstanding,
   output logic        crc_after_soh,
   output logic [7:0]  next_block
);
   typedef enum logic [2:0] {P_WAIT, P_CANWAIT, P_PACKET, P_FLUSH, P_DONE} phase_e;
   typedef enum logic [1:0] {M_C, M_NAK, M_NONE} mode_e;
   typedef enum logic [2:0] {
      R_NONE, R_ACK_END, R_ACK_ETX, R_ACK_CAN, R_NAK, R_CAN_SYNC, R_CAN_RETRY
   } reply_e;

   // register copies
   logic [20:0] capacity;
   logic [7:0]  retries;
   logic [15:0] timeout;

   // session state
   phase_e      ph;
   mode_e       mode;
   reply_e      reply;
   logic        crc_on, long_pkt, hdr_ok;
   logic [7:0]  exp_blk, wait_cnt, dup_left, blk, sum;
   logic [15:0] quiet, crc, rx_check;
   logic [10:0] byte_idx;
   int unsigned offset;
   logic [2:0]  end_code;

   rsp_type     step_out [3];
   int          n_out;
   rsp_type     expected_rsp [$];

   assign crc_after_soh = crc_on || (ph == P_WAIT && mode == M_C);
   assign next_block    = exp_blk;

   function automatic int unsigned store_limit();
      int unsigned a;
      a = 1 << ADDR_BITS;
      return (capacity < a) ? capacity : a;
   endfunction

   task automatic emit(input logic [7:0] txb, input bit wr, input logic [19:0] off,
                       input logic [7:0] d);
      rsp_type r;
      if (n_out >= 3) return;
      r = '0;
      r.tx_valid  = !wr;
      r.tx_byte   = wr ? 8'h00 : txb;
      r.wr_valid  = wr;
      r.wr_offset = wr ? off : 20'h0;
      r.wr_data   = wr ? d : 8'h00;
      step_out[n_out] = r;
      n_out++;
   endtask

   task automatic enter_wait();
      ph = P_WAIT;
      wait_cnt = 0;
      quiet = 0;
   endtask

   task automatic enter_flush(input reply_e r);
      ph = P_FLUSH;
      reply = r;
      quiet = 0;
   endtask

   task automatic new_session();
      enter_wait();
      mode = M_C;
      crc_on = 0;
      exp_blk = 1;
      dup_left = retries;
      byte_idx = 0;
      long_pkt = 0;
      blk = 0;
      hdr_ok = 0;
      crc = 0;
      sum = 0;
      rx_check = 0;
      offset = 0;
      reply = R_NONE;
      end_code = ST_NORMAL;
   endtask

   task automatic wait_fail();
      logic [7:0] lim;
      lim = (retries != 0) ? retries : 8'd1;
      if (mode == M_C) emit(CH_C, 0, 0, 0);
      else if (mode == M_NAK) emit(CH_NAK, 0, 0, 0);
      ph = P_WAIT;
      wait_cnt = wait_cnt + 8'd1;
      if (wait_cnt >= lim) begin
         if (mode == M_C) begin
            mode = M_NAK;
            wait_cnt = 0;
         end else begin
            enter_flush(R_CAN_SYNC);
         end
      end
   endtask

   task automatic finish_flush();
      reply_e p;
      p = reply;
      reply = R_NONE;
      case (p)
         R_NAK: begin
            emit(CH_NAK, 0, 0, 0);
            enter_wait();
         end
         R_CAN_SYNC, R_CAN_RETRY: begin
            repeat (3) emit(CH_CAN, 0, 0, 0);
            end_code = (p == R_CAN_SYNC) ? ST_SYNC : ST_RETRY;
            ph = P_DONE;
         end
         R_NONE: enter_wait();
         default: begin
            emit(CH_ACK, 0, 0, 0);
            end_code = (p == R_ACK_END) ? ST_NORMAL : (p == R_ACK_ETX) ? ST_ETX : ST_CANCEL;
            ph = P_DONE;
         end
      endcase
   endtask

   task automatic end_packet();
      int unsigned len, lim, avail;
      bit in_seq, prev, chk_ok;
      len = long_pkt ? 1024 : 128;
      in_seq = (blk == exp_blk);
      prev = (blk == 8'(exp_blk - 8'd1));
      chk_ok = crc_on ? (crc == rx_check) : (sum == rx_check[7:0]);
      if (hdr_ok && (in_seq || prev) && chk_ok) begin
         if (in_seq) begin
            lim = store_limit();
            avail = (lim > offset) ? lim - offset : 0;
            offset += (avail < len) ? avail : len;
            exp_blk = exp_blk + 8'd1;
            dup_left = retries;
         end else if (dup_left <= 1) begin
            dup_left = 0;
            enter_flush(R_CAN_RETRY);
            return;
         end else begin
            dup_left = dup_left - 8'd1;
         end
         emit(CH_ACK, 0, 0, 0);
         enter_wait();
      end else begin
         enter_flush(R_NAK);
      end
   endtask

   task automatic packet_byte(input logic [7:0] b);
      int unsigned len, total, i, off;
      len = long_pkt ? 1024 : 128;
      total = 2 + len + (crc_on ? 2 : 1);
      i = byte_idx;
      if (i == 0) begin
         blk = b;
      end else if (i == 1) begin
         hdr_ok = (b == ~blk);
      end else if (i < 2 + len) begin
         off = offset + i - 2;
         sum = sum + b;
         crc = crc ^ {b, 8'h00};
         repeat (8) crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
         if (hdr_ok && blk == exp_blk && off < store_limit())
            emit(0, 1, off[19:0], b);
      end else begin
         rx_check = {rx_check[7:0], b};
      end
      byte_idx = 11'(i + 1);
      if (byte_idx >= total) end_packet();
   endtask

   task automatic wait_byte(input logic [7:0] b);
      if (b == CH_SOH || b == CH_STX) begin
         if (mode == M_C) crc_on = 1;
         mode = M_NONE;
         long_pkt = (b == CH_STX);
         byte_idx = 0;
         blk = 0;
         hdr_ok = 0;
         crc = 0;
         sum = 0;
         rx_check = 0;
         ph = P_PACKET;
      end else if (b == CH_ETX) begin
         enter_flush(R_ACK_ETX);
      end else if (b == CH_EOT) begin
         enter_flush(R_ACK_END);
      end else if (b == CH_CAN) begin
         ph = P_CANWAIT;
      end else begin
         wait_fail();
      end
   endtask

   task automatic predict_item(input logic [1:0] op, input logic [7:0] b);
      n_out = 0;
      if (op == OP_START) begin
         new_session();
         return;
      end
      if ((op != OP_BYTE && op != OP_TICK) || ph == P_DONE) return;
      if (op == OP_BYTE) begin
         quiet = 0;
         case (ph)
            P_WAIT:    wait_byte(b);
            P_CANWAIT: if (b == CH_CAN) enter_flush(R_ACK_CAN); else wait_fail();
            P_PACKET:  packet_byte(b);
            default: ;
         endcase
      end else begin
         quiet = quiet + 16'd1;
         if (quiet >= timeout || quiet == 0) begin
            quiet = 0;
            if (ph == P_WAIT || ph == P_CANWAIT) wait_fail();
            else if (ph == P_PACKET) enter_flush(R_NAK);
            else if (ph == P_FLUSH) finish_flush();
         end
      end
      for (int k = 0; k < n_out; k++) begin
         step_out[k].committed_length = offset[20:0];
         step_out[k].done_res = (ph == P_DONE);
         step_out[k].status = (ph == P_DONE) ? end_code : ST_NORMAL;
         step_out[k].last = (k == n_out - 1);
         expected_rsp.push_back(step_out[k]);
      end
   endtask

   task automatic check_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         capacity = 21'h100000;
         retries = 8'd25;
         timeout = 16'd1000;
         new_session();
         expected_rsp.delete();
         errors = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual tx %0h wr %0h",
                        $time, rsp_tx_byte, rsp_wr_data);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("tx_valid", e.tx_valid, rsp_tx_valid);
               check_field("tx_byte", e.tx_byte, rsp_tx_byte);
               check_field("wr_valid", e.wr_valid, rsp_wr_valid);
               check_field("wr_offset", e.wr_offset, rsp_wr_offset);
               check_field("wr_data", e.wr_data, rsp_wr_data);
               check_field("committed_length", e.committed_length, rsp_committed_length);
               check_field("done_res", e.done_res, rsp_done_res);
               check_field("status", e.status, rsp_status);
               check_field("last", e.last, rsp_last);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY: capacity = csr_data;
               CSR_RETRIES:  retries = csr_data[7:0];
               CSR_TIMEOUT:  timeout = csr_data[15:0];
               default: ;
            endcase
         end
         if (push && !full) predict_item(req_operation, req_rx_byte);
      end
      outstanding = expected_rsp.size();
   end
endmodule

>>> bench/xmodem_1k_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmodem_1k_receiver_tb
// Drives control bytes, packets, ticks and session starts into the receiver
// under several register settings and stall patterns; a checker compares
// every result beat against its own session model.
// ----------------------------------------------------------------------------
module xmodem_1k_receiver_tb;
   import xmr_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_ITEMS = 24;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic [1:0]  req_operation = OP_BYTE;
   logic [7:0]  req_rx_byte = 0;
   logic        pop = 0;
   logic        csr_valid = 0;
   logic [1:0]  csr_index = CSR_CAPACITY;
   logic [20:0] csr_data = 0;

   wire         full, empty, csr_ready;
   wire         rsp_tx_valid, rsp_wr_valid, rsp_done_res, rsp_last;
   wire  [7:0]  rsp_tx_byte, rsp_wr_data;
   wire  [19:0] rsp_wr_offset;
   wire  [20:0] rsp_committed_length;
   wire  [2:0]  rsp_status;
   int          errors, outstanding;
   wire         crc_after_soh;
   wire  [7:0]  next_block;

   int          tx_idle_pct, rx_idle_pct;
   int          items_sent;
   int          cycles = 0;
   int unsigned ticks_now;
   logic        crc_snap;
   logic [7:0]  block_snap;

   xmodem_1k_receiver u_top (.*);

   xmr_checker u_checker (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) pop <= 0;
      else pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      repeat (8) x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
      return x;
   endfunction

   // push stays high across back-to-back beats; callers drop it with line_quiet
   task automatic send(input logic [1:0] op, input logic [7:0] b);
      bit took;
      if ($urandom_range(99) < tx_idle_pct) begin
         push <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1;
      req_operation <= op;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         took = !full;
         crc_snap = crc_after_soh;
         block_snap = next_block;
         @(posedge clock);
      end while (!took);
      items_sent++;
   endtask

   task automatic line_quiet();
      push <= 0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [20:0] value);
      bit took;
      line_quiet();
      wait (outstanding == 0);
      repeat (6) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 0;
      if (idx == CSR_TIMEOUT) ticks_now = value[15:0];
   endtask

   task automatic ticks(input int unsigned count);
      repeat (count) send(OP_TICK, 8'($urandom));
   endtask

   // blk_pick: 0 expected block, 1 previous block, else random
   task automatic send_packet(input bit big, input int blk_pick, input bit bad_hdr,
                              input bit bad_chk);
      logic [15:0] c;
      logic [7:0]  s, blk, d;
      bit          crc_on;
      c = 0;
      s = 0;
      send(OP_BYTE, big ? CH_STX : CH_SOH);
      crc_on = crc_snap;
      blk = (blk_pick == 0) ? block_snap :
            (blk_pick == 1) ? block_snap - 8'd1 : 8'($urandom);
      send(OP_BYTE, blk);
      send(OP_BYTE, bad_hdr ? blk : ~blk);
      repeat (big ? 1024 : 128) begin
         d = 8'($urandom);
         c = crc_next(c, d);
         s = s + d;
         send(OP_BYTE, d);
      end
      if (bad_chk) begin
         c = c ^ 16'h0100;
         s = s ^ 8'h01;
      end
      if (crc_on) begin
         send(OP_BYTE, c[15:8]);
         send(OP_BYTE, c[7:0]);
      end else begin
         send(OP_BYTE, s);
      end
   endtask

   // short events only: packets are cut off by a timeout after a few bytes
   task automatic random_events(input int quota);
      int r, start_count;
      logic [7:0] blk;
      start_count = items_sent;
      while (items_sent - start_count < quota) begin
         r = $urandom_range(99);
         if (r < 30) begin
            send(OP_BYTE, $urandom_range(1) ? CH_STX : CH_SOH);
            blk = $urandom_range(1) ? block_snap : 8'($urandom);
            send(OP_BYTE, blk);
            send(OP_BYTE, ($urandom_range(7) == 0) ? blk : ~blk);
            repeat ($urandom_range(4)) send(OP_BYTE, 8'($urandom));
            ticks(ticks_now);
         end else if (r < 45) begin
            ticks($urandom_range(1, ticks_now + 1));
         end else if (r < 60) begin
            send(OP_BYTE, 8'($urandom));
         end else if (r < 72) begin
            send(OP_BYTE, CH_CAN);
            send(OP_BYTE, $urandom_range(1) ? CH_CAN : 8'($urandom));
            ticks(ticks_now);
         end else if (r < 86) begin
            send(OP_BYTE, $urandom_range(1) ? CH_EOT : CH_ETX);
            ticks(ticks_now);
            send(OP_START, 8'($urandom));
         end else begin
            send(OP_START, 8'($urandom));
         end
      end
   endtask

   initial begin
      items_sent = 0;
      ticks_now = 1000;
      tx_idle_pct = 23;
      rx_idle_pct = 59;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      csr_write(CSR_TIMEOUT, 21'd2);
      csr_write(CSR_RETRIES, 21'd2);
      csr_write(CSR_CAPACITY, 21'd100);

      // wait timeouts, C to NAK mode, lone CAN, sync loss, ignored bytes
      send(OP_START, 8'h00);
      send(OP_UNUSED, 8'hff);
      ticks(4);
      send(OP_BYTE, 8'h55);
      send(OP_BYTE, CH_CAN);
      send(OP_BYTE, 8'h00);
      ticks(2);
      send(OP_BYTE, CH_SOH);
      send(OP_TICK, 8'haa);
      send(OP_START, 8'h00);
      // first packet picks crc mode and overruns capacity
      send_packet(0, 0, 0, 0);
      send(OP_BYTE, CH_EOT);
      ticks(2);

      // every expected result is popped before the pause ends
      line_quiet();
      wait (outstanding == 0);

      // checksum mode after NAK mode; a duplicate with no retries left aborts
      tx_idle_pct = 59;
      rx_idle_pct = 23;
      csr_write(CSR_TIMEOUT, 21'd1);
      csr_write(CSR_RETRIES, 21'd1);
      csr_write(CSR_CAPACITY, 21'd0);
      send(OP_START, 8'h00);
      ticks(1);
      send_packet(0, 1, 0, 0);
      ticks(1);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      csr_write(CSR_TIMEOUT, 21'd3);
      csr_write(CSR_RETRIES, 21'd3);
      csr_write(CSR_CAPACITY, 21'd1500);
      send(OP_START, 8'h00);
      random_events(RANDOM_ITEMS);

      line_quiet();
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
